/* rtl/four_floor_elevator_controller_unit_defines.svh */
// ----------------------------------------------------------------------------
// Four-floor elevator controller: assertion macros
// Concurrent check helpers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef FOUR_FLOOR_ELEVATOR_CONTROLLER_UNIT_DEFINES_SVH
`define FOUR_FLOOR_ELEVATOR_CONTROLLER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define FFEC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ffec check failed");
// next-cycle implication
`define FFEC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ffec check failed");
`else
`define FFEC_ASSERT_NOW(label, clk, rstn, ante, cons)
`define FFEC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

/* rtl/ffec_pkg.sv */
// ----------------------------------------------------------------------------
// ffec_pkg
// Types and constants shared by the elevator controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ffec_pkg;

    localparam int unsigned FLOORS = 4;

    localparam logic [7:0] PHASE_RESET = 8'h11;
    localparam logic [3:0] COIL_MASK   = 4'hF;
    localparam logic [7:0] SPF_RESET   = 8'd8;
    localparam logic [2:0] FLOOR_BOT   = 3'd1;
    localparam logic [2:0] FLOOR_TOP   = 3'(FLOORS);

    typedef enum logic [1:0] {
        HALT_RUN   = 2'd0,
        HALT_STOP  = 2'd1,
        HALT_ALARM = 2'd2
    } halt_t;

    // Controller state carried from tick to tick
    typedef struct packed {
        logic [2:0] current_floor;
        logic       going_up;
        logic       parked_here;
        logic [7:0] step_counter;
        logic [3:0] up_requests;
        logic [3:0] down_requests;
        logic [7:0] phase_pattern;
        halt_t      halt_mode;
        logic       await_start;
        logic       alarm_blink;
    } ffec_state_t;

    // One button scan tick
    typedef struct packed {
        logic       alarm_button;
        logic       stop_button;
        logic       start_button;
        logic [3:0] car_calls;
        logic [2:0] hall_down_calls;
        logic [2:0] hall_up_calls;
    } ffec_in_t;

    // One result per tick
    typedef struct packed {
        logic       alarm_lamp;
        logic       down_lamp;
        logic       up_lamp;
        logic [2:0] floor_display;
        logic [3:0] coil_drive;
    } ffec_out_t;

    localparam ffec_state_t STATE_RESET = '{
        current_floor: FLOOR_BOT,
        going_up:      1'b1,
        parked_here:   1'b0,
        step_counter:  8'd0,
        up_requests:   4'd0,
        down_requests: 4'd0,
        phase_pattern: PHASE_RESET,
        halt_mode:     HALT_RUN,
        await_start:   1'b0,
        alarm_blink:   1'b0
    };

    // Request bit of a floor (1..4)
    function automatic logic [3:0] floor_bit(input logic [2:0] f);
        return 4'(4'b0001 << 2'(f - 3'd1));
    endfunction

endpackage

`default_nettype wire

/* rtl/ffec_step.sv */
// ----------------------------------------------------------------------------
// ffec_step
// Next-state and result logic for one scan tick: motor step and floor
// arrival, hall call latching, car call and button handling.
// ----------------------------------------------------------------------------
`default_nettype none

module ffec_step (
    input  wire ffec_pkg::ffec_state_t state_i,
    input  wire ffec_pkg::ffec_in_t    item_i,
    input  wire logic [7:0]            spf_i,
    output ffec_pkg::ffec_state_t      state_o,
    output ffec_pkg::ffec_out_t        result_o
);
    import ffec_pkg::*;

    ffec_state_t st;
    logic [3:0]  coil;
    logic        stepped;
    logic        hold;
    logic        car_hit;
    logic        found;
    logic [7:0]  limit;
    logic [3:0]  u_snap;
    logic [3:0]  d_snap;
    logic [5:0]  hall_vec;
    logic [2:0]  hf;
    logic [2:0]  cf;
    logic [3:0]  req;
    logic [3:0]  above;
    logic [3:0]  below;

    always_comb begin
        st       = state_i;
        coil     = 4'd0;
        stepped  = 1'b0;
        hold     = 1'b0;
        car_hit  = 1'b0;
        found    = 1'b0;
        limit    = (spf_i == 8'd0) ? 8'd1 : spf_i;
        u_snap   = 4'd0;
        d_snap   = 4'd0;
        hall_vec = {item_i.hall_down_calls, item_i.hall_up_calls};
        hf       = 3'd0;
        cf       = 3'd0;
        req      = 4'd0;
        above    = 4'd0;
        below    = 4'd0;

        if (st.halt_mode != HALT_RUN) begin
            // halted: only start is looked at
            if (item_i.start_button) begin
                st.halt_mode   = HALT_RUN;
                st.await_start = 1'b0;
                st.alarm_blink = 1'b0;
            end else if (st.halt_mode == HALT_ALARM) begin
                st.alarm_blink = ~st.alarm_blink;
            end
        end else begin
            // motor step
            if (!st.await_start && !st.parked_here &&
                (((st.up_requests & 4'h7) | (st.down_requests & 4'hE)) != 4'd0)) begin
                if (st.going_up && st.current_floor >= FLOOR_TOP) begin
                    st.going_up = 1'b0;
                end else if (!st.going_up && st.current_floor <= FLOOR_BOT) begin
                    st.going_up = 1'b1;
                end
                st.step_counter = st.step_counter + 8'd1;
                if (st.step_counter >= limit) begin
                    st.step_counter = 8'd0;
                    u_snap = st.up_requests;
                    d_snap = st.down_requests;
                    // floor arrival: stop-or-pass rules per floor
                    if (st.going_up) begin
                        st.current_floor = st.current_floor + 3'd1;
                        if (st.current_floor == 3'd2) begin
                            if (u_snap[1]) begin
                                st.up_requests[1] = 1'b0;
                                st.going_up = 1'b1;
                                st.parked_here = 1'b1;
                            end else if (d_snap[1] && !u_snap[2] && !(d_snap[2] | d_snap[3])) begin
                                st.down_requests[1] = 1'b0;
                                st.going_up = 1'b0;
                                st.parked_here = 1'b1;
                            end
                            hold = st.parked_here;
                        end else if (st.current_floor == 3'd3) begin
                            if (u_snap[2]) begin
                                st.up_requests[2] = 1'b0;
                                st.going_up = 1'b1;
                                st.parked_here = 1'b1;
                            end else if (d_snap[2] && !d_snap[3]) begin
                                st.down_requests[2] = 1'b0;
                                st.going_up = 1'b0;
                                st.parked_here = 1'b1;
                            end
                            hold = st.parked_here;
                        end else begin
                            if (d_snap[3]) begin
                                st.down_requests[3] = 1'b0;
                                st.going_up = 1'b0;
                                st.parked_here = 1'b1;
                            end
                            hold = 1'b1;
                        end
                    end else begin
                        st.current_floor = st.current_floor - 3'd1;
                        if (st.current_floor == 3'd1) begin
                            if (u_snap[0]) begin
                                st.up_requests[0] = 1'b0;
                                st.going_up = 1'b1;
                                st.parked_here = 1'b1;
                            end
                            hold = 1'b1;
                        end else if (st.current_floor == 3'd2) begin
                            if (d_snap[1]) begin
                                st.down_requests[1] = 1'b0;
                                st.going_up = 1'b0;
                                st.parked_here = 1'b1;
                            end else if (u_snap[1] && !u_snap[0]) begin
                                st.up_requests[1] = 1'b0;
                                st.going_up = 1'b1;
                                st.parked_here = 1'b1;
                            end
                            hold = st.parked_here;
                        end else begin
                            if (d_snap[2]) begin
                                st.down_requests[2] = 1'b0;
                                st.going_up = 1'b0;
                                st.parked_here = 1'b1;
                            end else if (!(u_snap[0] | u_snap[1]) && !d_snap[1] && u_snap[2]) begin
                                st.up_requests[2] = 1'b0;
                                st.going_up = 1'b1;
                                st.parked_here = 1'b1;
                            end
                            hold = st.parked_here;
                        end
                    end
                end
                if (!hold) begin
                    coil = st.phase_pattern[3:0] & COIL_MASK;
                    if (st.going_up) begin
                        st.phase_pattern = {st.phase_pattern[6:0], st.phase_pattern[7]};
                    end else begin
                        st.phase_pattern = {st.phase_pattern[0], st.phase_pattern[7:1]};
                    end
                    stepped = 1'b1;
                end
            end

            // hall scan: up buttons floors 1..3, then down buttons floors 2..4
            for (int i = 0; i < 6; i++) begin
                if (hall_vec[i]) begin
                    hf = (i < 3) ? 3'(i + 1) : 3'(i - 1);
                    if (i < 3) begin
                        st.up_requests = st.up_requests | floor_bit(hf);
                    end else begin
                        st.down_requests = st.down_requests | floor_bit(hf);
                    end
                    if (st.parked_here) begin
                        if (st.current_floor > hf) begin
                            st.going_up = 1'b0;
                            st.parked_here = 1'b0;
                        end else if (st.current_floor < hf) begin
                            st.going_up = 1'b1;
                            st.parked_here = 1'b0;
                        end
                    end
                    if (st.current_floor == hf) begin
                        st.parked_here = 1'b1;
                    end
                end
            end

            // car scan, lowest floor button first
            priority if (item_i.car_calls != 4'd0) begin
                car_hit = 1'b1;
                priority if (item_i.car_calls[0]) cf = 3'd1;
                else if (item_i.car_calls[1])     cf = 3'd2;
                else if (item_i.car_calls[2])     cf = 3'd3;
                else                              cf = 3'd4;
                if (cf > st.current_floor) begin
                    if (cf == FLOOR_TOP) st.down_requests = st.down_requests | floor_bit(cf);
                    else                 st.up_requests   = st.up_requests | floor_bit(cf);
                    st.parked_here = 1'b0;
                end else if (cf < st.current_floor) begin
                    if (cf == FLOOR_BOT) st.up_requests   = st.up_requests | floor_bit(cf);
                    else                 st.down_requests = st.down_requests | floor_bit(cf);
                    st.parked_here = 1'b0;
                end else begin
                    st.parked_here = 1'b1;
                end
            end else if (item_i.start_button) begin
                st.parked_here = 1'b0;
            end else if (item_i.stop_button) begin
                st.halt_mode = HALT_STOP;
            end else if (item_i.alarm_button) begin
                st.halt_mode   = HALT_ALARM;
                st.alarm_blink = 1'b1;
            end else begin
                // reverse when nothing lies ahead
                req   = st.up_requests | st.down_requests;
                above = req & 4'(4'hF << st.current_floor);
                below = req & ~4'(4'hF << 2'(st.current_floor - 3'd1));
                if (st.going_up) begin
                    if (above != 4'd0) found = 1'b1;
                    else               st.going_up = 1'b0;
                end
                if (!st.going_up) begin
                    if (below != 4'd0) found = 1'b1;
                    if (!found)        st.going_up = 1'b1;
                end
            end

            if (car_hit && !st.await_start && !stepped) st.await_start = 1'b1;
            if (st.await_start && item_i.start_button)  st.await_start = 1'b0;
            if (st.halt_mode != HALT_RUN)              coil = 4'd0;
        end
    end

    assign state_o                = st;
    assign result_o.coil_drive    = coil;
    assign result_o.floor_display = st.current_floor;
    assign result_o.up_lamp       = (st.halt_mode == HALT_STOP) ? 1'b0 : st.going_up;
    assign result_o.down_lamp     = (st.halt_mode == HALT_STOP) ? 1'b0 : ~st.going_up;
    assign result_o.alarm_lamp    = st.alarm_blink;

endmodule

`default_nettype wire

/* rtl/four_floor_elevator_controller_unit.sv */
// ----------------------------------------------------------------------------
// four_floor_elevator_controller_unit
// An input transfer passes the input register, then the result register.
// Throughput: one scan tick per cycle while the result side is not stalled by
// m_tready; the state update through ffec_step is combinational.
// Reset (aresetn low, synchronous): car at floor one heading up, no requests,
// phase 0x11, running, steps_per_floor 8, both stages empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "four_floor_elevator_controller_unit_defines.svh"

module four_floor_elevator_controller_unit (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration: steps_per_floor
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [7:0]  cfg_data,
    // input: [2:0] hall_up_calls, [5:3] hall_down_calls, [9:6] car_calls,
    //        [10] start_button, [11] stop_button, [12] alarm_button
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,
    // result: [3:0] coil_drive, [6:4] floor_display, [7] up_lamp,
    //         [8] down_lamp, [9] alarm_lamp
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata
);
    import ffec_pkg::*;

    logic [7:0]  spf_reg;
    logic        in_valid_reg;
    ffec_in_t    in_item_reg;
    logic        out_valid_reg;
    ffec_out_t   out_item_reg;
    ffec_state_t state_reg;
    ffec_state_t state_next;
    ffec_out_t   result_next;
    logic        advance;

    // stage hand-off
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    ffec_step u_step (
        .state_i  (state_reg),
        .item_i   (in_item_reg),
        .spf_i    (spf_reg),
        .state_o  (state_next),
        .result_o (result_next)
    );

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spf_reg <= SPF_RESET;
        end else if (cfg_valid && cfg_ready) begin
            spf_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= ffec_in_t'(s_tdata[12:0]);
        end
    end

    // controller state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_item_reg};

    // checks
    `FFEC_ASSERT_NOW(a_floor_range, aclk, aresetn, 1'b1,
        state_reg.current_floor >= FLOOR_BOT && state_reg.current_floor <= FLOOR_TOP)
    `FFEC_ASSERT_NOW(a_phase_pair, aclk, aresetn, 1'b1,
        $countones(state_reg.phase_pattern) == 2)
    `FFEC_ASSERT_NOW(a_coil_only_running, aclk, aresetn,
        out_valid_reg && out_item_reg.coil_drive != 4'd0, state_reg.halt_mode == HALT_RUN)
    `FFEC_ASSERT_NEXT(a_input_held, aclk, aresetn, in_valid_reg && !advance,
        in_valid_reg && $stable(in_item_reg) && $stable(state_reg))

endmodule

`default_nettype wire
